// File: design/orbwa_pkg.sv
// Shared types and constants of the overwrite ring buffer with running average.
package orbwa_pkg;

   // Fixed right shift that turns the running sum into the reported average.
   localparam int AVG_SHIFT = 7;

   // Operation codes carried in the mode field of an input item.
   localparam logic [1:0] MODE_PUSH  = 2'd0;
   localparam logic [1:0] MODE_POP   = 2'd1;
   localparam logic [1:0] MODE_QUERY = 2'd2;

   // Per-cycle control broadcast to every storage cell.
   typedef struct packed {
      logic shift;   // move every sample one cell toward the head
      logic load;    // store the new sample at the write position
   } cell_ctrl_type;

endpackage

// File: design/orbwa_ifs.sv
// Valid/ready channel interfaces for the request and response items.
interface orbwa_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic [1:0]                    mode;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, mode, sample, input ready);
   modport sink   (input valid, mode, sample, output ready);
endinterface

interface orbwa_rsp_if #(
   parameter int SAMPLE_BITS = 16,
   parameter int CNT_W       = 8
);
   logic                          valid;
   logic                          ready;
   logic                          head_valid;
   logic signed [SAMPLE_BITS-1:0] head_value;
   logic [CNT_W-1:0]              count;
   logic signed [SAMPLE_BITS-1:0] average;

   modport source (output valid, head_valid, head_value, count, average, input ready);
   modport sink   (input valid, head_valid, head_value, count, average, output ready);
endinterface

// File: design/overwrite_ring_buffer_with_average.sv
// Top level: sample row of cells, fill count, running sum and registered response.
//
//   Channel   Dir   Handshake      Item contents
//   req_chan  in    valid/ready    mode, sample
//   rsp_chan  out   valid/ready    head_valid, head_value, count, average
//
// One item is accepted per cycle; its response appears in the next cycle from the
// output register. The rate is set by the single update of the cell row and of the
// running sum. The oldest sample always sits in cell zero, so a drop shifts the whole
// row by one. Synchronous reset empties the buffer at once, with no clearing pass.
// A stalled response holds the output register and blocks new items only while it
// waits.
module overwrite_ring_buffer_with_average #(
   parameter int DEPTH       = 128,
   parameter int SAMPLE_BITS = 16
) (
   input logic               clock,
   input logic               reset,
   orbwa_req_if.sink         req_chan,
   orbwa_rsp_if.source       rsp_chan
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = SAMPLE_BITS + $clog2(DEPTH);
   localparam int EXT_W = SUM_W + SAMPLE_BITS;

   // Control and running state.
   logic [CNT_W-1:0]              count_ff;
   logic [CNT_W-1:0]              count_in;
   logic signed [SUM_W-1:0]       sum_ff;
   logic signed [SUM_W-1:0]       sum_in;

   // Response register.
   logic                          rsp_valid_ff;
   logic                          head_valid_ff;
   logic signed [SAMPLE_BITS-1:0] head_value_ff;
   logic [CNT_W-1:0]              count_out_ff;
   logic signed [SAMPLE_BITS-1:0] average_ff;

   logic                          accept;
   logic                          is_push;
   logic                          is_pop;
   logic                          full;
   logic                          empty;
   logic [CNT_W-1:0]              wr_pos;
   orbwa_pkg::cell_ctrl_type      ctrl;
   logic signed [SAMPLE_BITS-1:0] drop_value;
   logic signed [SAMPLE_BITS-1:0] add_value;
   logic signed [EXT_W-1:0]       sum_wide;
   logic signed [EXT_W-1:0]       avg_wide;
   logic signed [SAMPLE_BITS-1:0] head_next;

   logic signed [SAMPLE_BITS-1:0] cell_now   [DEPTH];
   logic signed [SAMPLE_BITS-1:0] cell_next  [DEPTH];
   logic signed [SAMPLE_BITS-1:0] cell_upper [DEPTH];

   // Handshake: a new item enters whenever the response register is free or draining.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   // Decode the operation; an unused code behaves as a query.
   always_comb begin
      is_push = 1'b0;
      is_pop  = 1'b0;
      case (req_chan.mode)
         orbwa_pkg::MODE_PUSH:  is_push = 1'b1;
         orbwa_pkg::MODE_POP:   is_pop  = 1'b1;
         orbwa_pkg::MODE_QUERY: is_pop  = 1'b0;
         default:               is_pop  = 1'b0;
      endcase
   end

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);

   // A push into a full row or a pop of a non-empty row drops the head and shifts.
   assign ctrl.shift = accept && ((is_push && full) || (is_pop && !empty));
   assign ctrl.load  = accept && is_push;
   assign wr_pos     = full ? CNT_W'(DEPTH - 1) : count_ff;

   // Row of storage cells, each fed by its upper neighbor; the top cell is fed zero.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == DEPTH - 1) begin : g_top
         assign cell_upper[i] = '0;
      end else begin : g_mid
         assign cell_upper[i] = cell_now[i+1];
      end

      orbwa_cell #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .CNT_W       (CNT_W),
         .INDEX       (i)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .wr_pos      (wr_pos),
         .new_sample  (req_chan.sample),
         .upper_value (cell_upper[i]),
         .value_now   (cell_now[i]),
         .value_next  (cell_next[i])
      );
   end

   // Next fill count.
   always_comb begin
      count_in = count_ff;
      if (accept && is_push && !full) begin
         count_in = count_ff + CNT_W'(1);
      end else if (accept && is_pop && !empty) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // Running sum: subtract the dropped head, add the pushed sample.
   assign drop_value = ctrl.shift ? cell_now[0] : '0;
   assign add_value  = ctrl.load ? req_chan.sample : '0;
   assign sum_in     = sum_ff - SUM_W'(drop_value) + SUM_W'(add_value);

   // Average is the floor of the sum over the fixed power of two.
   assign sum_wide  = EXT_W'(sum_in);
   assign avg_wide  = sum_wide >>> orbwa_pkg::AVG_SHIFT;
   assign head_next = (count_in != '0) ? cell_next[0] : '0;

   // State and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         head_valid_ff <= (count_in != '0);
         head_value_ff <= head_next;
         count_out_ff  <= count_in;
         average_ff    <= avg_wide[SAMPLE_BITS-1:0];
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.head_valid = head_valid_ff;
   assign rsp_chan.head_value = head_value_ff;
   assign rsp_chan.count      = count_out_ff;
   assign rsp_chan.average    = average_ff;

`ifndef SYNTHESIS
   // The fill count never passes the row length.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count exceeds depth");

   // Every accepted item leaves a response in the next cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted item produced no response");

   // The head flag agrees with the reported count.
   a_head_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (head_valid_ff == (count_out_ff != '0)))
      else $error("head flag disagrees with count");

   // An empty buffer reports a zero head and a zero average.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !head_valid_ff) |-> (head_value_ff == '0 && average_ff == '0))
      else $error("empty buffer reports nonzero head or average");
`endif

endmodule

// File: design/orbwa_cell.sv
// One storage cell of the sample row: holds one sample and takes its neighbor's on a shift.
module orbwa_cell #(
   parameter int SAMPLE_BITS = 16,
   parameter int CNT_W       = 8,
   parameter int INDEX       = 0
) (
   input  logic                          clock,
   input  orbwa_pkg::cell_ctrl_type      ctrl,
   input  logic [CNT_W-1:0]              wr_pos,
   input  logic signed [SAMPLE_BITS-1:0] new_sample,
   input  logic signed [SAMPLE_BITS-1:0] upper_value,
   output logic signed [SAMPLE_BITS-1:0] value_now,
   output logic signed [SAMPLE_BITS-1:0] value_next
);

   logic signed [SAMPLE_BITS-1:0] value_ff;
   logic signed [SAMPLE_BITS-1:0] value_in;
   logic                          write_here;

   // This cell is the write target when the write position matches its place in the row.
   assign write_here = ctrl.load && (wr_pos == CNT_W'(INDEX));

   // A new sample wins over a shift; otherwise the cell takes its upper neighbor or holds.
   always_comb begin
      if (write_here) begin
         value_in = new_sample;
      end else if (ctrl.shift) begin
         value_in = upper_value;
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_now  = value_ff;
   assign value_next = value_in;

endmodule
